/* hdl/tos_pkg.sv */
// Package for the triangle oscillator: widths, types, reset values and helpers.
`default_nettype none
package tos_pkg;

  localparam int FREQ_W  = 32;
  localparam int PHASE_W = 32;
  localparam int SYNC_W  = 33;
  localparam int SCALE_W = 48;
  localparam int WAVE_W  = 16;

  // step_scale splits into a 32-bit low half and a 16-bit high half
  localparam int SCALE_LO_W = 32;
  localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;

  // freq * lo, bits 64:32, and freq * hi, bits 47:0
  localparam int PROD_LO_W = FREQ_W + 1;
  localparam int PROD_HI_W = FREQ_W + SCALE_HI_W;
  localparam int STEP_SUM_W = PROD_HI_W + 1;

  localparam logic [SCALE_W-1:0] STEP_SCALE_RST = 48'd1501199875790;
  localparam logic [PHASE_W-1:0] HALF_CYCLE     = 32'h8000_0000;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic signed [WAVE_W-1:0] wave_t;

  // stage advance strobes issued by the top-level flow control
  typedef struct packed {
    logic prod;
    logic step;
    logic out;
  } tos_adv_t;

  // per-beat data carried alongside the step pipeline
  typedef struct packed {
    phase_t offset;
    logic   sync_hit;
    phase_t sync_val;
  } tos_side_t;

  // fold phase into a triangle: p, 32768 - p, or p - 65536 (same bits as p)
  function automatic wave_t tri_fold(input phase_t ph);
    logic [WAVE_W-1:0] p;
    logic [WAVE_W:0]   mid;
    begin
      p   = ph[PHASE_W-1 -: WAVE_W];
      mid = 17'h1_0000 - {1'b0, p} - 17'h0_8000;
      if (p[WAVE_W-1] != p[WAVE_W-2]) begin
        tri_fold = wave_t'(mid[WAVE_W-1:0]);
      end else begin
        tri_fold = wave_t'(p);
      end
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/tos_step.sv */
// Phase step unit: split multiply by step_scale, then sum and clip to half a cycle.
`default_nettype none
module tos_step (
  input  wire logic                          clk,
  input  wire tos_pkg::tos_adv_t             adv,
  input  wire logic [tos_pkg::SCALE_W-1:0]   step_scale,
  input  wire logic signed [tos_pkg::FREQ_W-1:0] freq,
  input  wire tos_pkg::tos_side_t            side_in,
  output tos_pkg::phase_t                    step,
  output tos_pkg::tos_side_t                 side_out
);
  import tos_pkg::*;

  logic signed [FREQ_W+SCALE_LO_W:0]  prod_lo;
  logic signed [PROD_HI_W:0]          prod_hi;
  logic signed [PROD_LO_W-1:0]        lo_r;
  logic signed [PROD_HI_W-1:0]        hi_r;
  tos_side_t                          side_p_r;
  logic signed [STEP_SUM_W-1:0]       sum;
  logic [STEP_SUM_W-1:31]             top_bits;
  phase_t                             step_nxt;
  phase_t                             step_r;
  tos_side_t                          side_s_r;

  // stage 1: two products, 32 x 33 and 32 x 17 bits
  assign prod_lo = freq * $signed({1'b0, step_scale[SCALE_LO_W-1:0]});
  assign prod_hi = freq * $signed({1'b0, step_scale[SCALE_W-1:SCALE_LO_W]});

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      lo_r     <= prod_lo[FREQ_W+SCALE_LO_W:SCALE_LO_W];
      hi_r     <= prod_hi[PROD_HI_W-1:0];
      side_p_r <= side_in;
    end
  end

  // stage 2: floor(freq * scale / 2^32) = freq*hi + (freq*lo >>> 32)
  assign sum = {{(STEP_SUM_W-PROD_LO_W){lo_r[PROD_LO_W-1]}}, lo_r}
             + {hi_r[PROD_HI_W-1], hi_r};
  assign top_bits = sum[STEP_SUM_W-1:31];

  // in range [-2^31, 2^31) passes; anything else saturates, and both limits
  // are the same phase, 0x8000_0000
  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      step_nxt = sum[PHASE_W-1:0];
    end else begin
      step_nxt = HALF_CYCLE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.step) begin
      step_r   <= step_nxt;
      side_s_r <= side_p_r;
    end
  end

  assign step     = step_r;
  assign side_out = side_s_r;

endmodule
`default_nettype wire

/* hdl/tos_phase.sv */
// Phase accumulator with offset modulation and hard sync, plus triangle output register.
`default_nettype none
module tos_phase (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tos_pkg::tos_adv_t adv,
  input  wire logic              fire,
  input  wire tos_pkg::phase_t   step,
  input  wire tos_pkg::tos_side_t side,
  output tos_pkg::wave_t         wave
);
  import tos_pkg::*;

  phase_t phase_acc_r, phase_acc_nxt;
  phase_t prev_offset_r;
  phase_t phase_now;
  wave_t  wave_r;

  always_comb begin
    if (side.sync_hit) begin
      phase_now = side.sync_val;
    end else begin
      phase_now = phase_acc_r + (side.offset - prev_offset_r);
    end
    phase_acc_nxt = phase_now + step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r   <= '0;
      prev_offset_r <= '0;
    end else if (fire) begin
      phase_acc_r   <= phase_acc_nxt;
      prev_offset_r <= side.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.out) begin
      wave_r <= tri_fold(phase_now);
    end
  end

  assign wave = wave_r;

endmodule
`default_nettype wire

/* hdl/triangle_oscillator_sync_pm.sv */
// Top level of the triangle oscillator with phase modulation and hard sync.
`default_nettype none
// Triangle oscillator, one audio sample per beat. Each input beat carries a
// signed Q24.8 frequency in Hz, an unsigned Q0.32 phase offset and a 33-bit
// sync word; each one gives exactly one output beat, a signed Q2.14 triangle
// sample in [-16384, 16384]. The block takes a beat every cycle unless every
// stage is full and the output is stalled, and a result has passed four
// registers (input, product, step, output). The phase accumulator
// loop (offset delta, or sync value, plus step) closes through the
// phase register in the last stage, which is what sets the
// one-beat-per-cycle figure. Phase step is
// floor(frequency * step_scale / 2^32), clipped to plus or minus half a
// cycle; the 32 x 48 product is done as two narrower products. A sync word in
// 1..2^32 loads the phase (2^32 reads as zero); 0 or anything above 2^32
// means no sync. Without sync, the change of the offset since the previous
// beat is added to the phase. All phase sums wrap modulo one cycle.
// step_scale resets to round(2^56 / 48000) and is written through the cfg
// port, which is always ready; write it only while the block holds no beat.
// Stall stops each stage only when the stage below it is full, so bubbles
// close up and new beats are taken while a finished sample waits. No
// clearing pass after reset.
module triangle_oscillator_sync_pm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input beat
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [tos_pkg::FREQ_W-1:0] in_frequency,
  input  wire logic [tos_pkg::PHASE_W-1:0]       in_offset,
  input  wire logic [tos_pkg::SYNC_W-1:0]        in_sync_phase,
  // result beat
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [tos_pkg::WAVE_W-1:0]      out_wave,
  // step_scale write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tos_pkg::SCALE_W-1:0]       cfg_step_scale
);
  import tos_pkg::*;

  logic [SCALE_W-1:0]        step_scale_r;

  // stage valids: input, product, step, output
  logic v_in_r,   v_in_nxt;
  logic v_prod_r, v_prod_nxt;
  logic v_step_r, v_step_nxt;
  logic v_out_r,  v_out_nxt;

  logic en_in;
  tos_adv_t adv;
  logic fire;

  // input register (payload, no reset)
  logic signed [FREQ_W-1:0]  freq_r;
  tos_side_t                 side_in_r;
  tos_side_t                 side_in_nxt;

  phase_t    step;
  tos_side_t side_step;
  wave_t     wave;

  // ---------------------------------------------------------------------
  // Configuration: single register, always ready
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_scale_r <= STEP_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      step_scale_r <= cfg_step_scale;
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: a stage moves when it is empty or the next one moves
  // ---------------------------------------------------------------------
  assign adv.out  = !v_out_r  || !out_stall;
  assign adv.step = !v_step_r || adv.out;
  assign adv.prod = !v_prod_r || adv.step;
  assign en_in    = !v_in_r   || adv.prod;
  assign in_stall = !en_in;

  // a beat leaves the step stage into the output register: phase advances
  assign fire = adv.out && v_step_r;

  always_comb begin
    v_in_nxt   = en_in    ? in_valid : v_in_r;
    v_prod_nxt = adv.prod ? v_in_r   : v_prod_r;
    v_step_nxt = adv.step ? v_prod_r : v_step_r;
    v_out_nxt  = adv.out  ? v_step_r : v_out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r   <= 1'b0;
      v_prod_r <= 1'b0;
      v_step_r <= 1'b0;
      v_out_r  <= 1'b0;
    end else begin
      v_in_r   <= v_in_nxt;
      v_prod_r <= v_prod_nxt;
      v_step_r <= v_step_nxt;
      v_out_r  <= v_out_nxt;
    end
  end

  // sync decode: 1..2^32 loads the phase, 0 and values above 2^32 do not
  always_comb begin
    side_in_nxt.offset   = in_offset;
    side_in_nxt.sync_val = in_sync_phase[PHASE_W-1:0];
    if (in_sync_phase[SYNC_W-1]) begin
      side_in_nxt.sync_hit = (in_sync_phase[PHASE_W-1:0] == '0);
    end else begin
      side_in_nxt.sync_hit = (in_sync_phase[PHASE_W-1:0] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) begin
      freq_r    <= in_frequency;
      side_in_r <= side_in_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  tos_step u_step (
    .clk        (clk),
    .adv        (adv),
    .step_scale (step_scale_r),
    .freq       (freq_r),
    .side_in    (side_in_r),
    .step       (step),
    .side_out   (side_step)
  );

  tos_phase u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .fire  (fire),
    .step  (step),
    .side  (side_step),
    .wave  (wave)
  );

  assign out_valid = v_out_r;
  assign out_wave  = wave;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // input is only held off when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_in_r && v_prod_r && v_step_r && v_out_r && out_stall))
    else $error("input stalled with a free pipeline stage");

  // a new result only comes out of a full step stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v_step_r))
    else $error("output beat without a beat in the step stage");

  // triangle stays within [-1, 1]
  a_wave_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wave >= -16'sd16384 && out_wave <= 16'sd16384))
    else $error("wave sample out of range");

  // an accepted beat lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_in_r)
    else $error("accepted beat lost at the input register");

endmodule
`default_nettype wire

/* dv/tos_wave_checker.sv */
// Checker for the triangle oscillator: watches the beats, predicts each sample and compares.
`default_nettype none
module tos_wave_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic signed [tos_pkg::FREQ_W-1:0]   in_frequency,
  input  wire logic [tos_pkg::PHASE_W-1:0]         in_offset,
  input  wire logic [tos_pkg::SYNC_W-1:0]          in_sync_phase,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [tos_pkg::WAVE_W-1:0]   out_wave,
  input  wire logic                                cfg_valid,
  input  wire logic                                cfg_ready,
  input  wire logic [tos_pkg::SCALE_W-1:0]         cfg_step_scale,
  input  wire logic                                end_check,
  output int                                       fail_count,
  output int                                       waves_pending,
  output int                                       waves_checked,
  output int                                       sync_loads,
  output int                                       clipped_steps
);

  timeunit 1ns;
  timeprecision 1ps;

  import tos_pkg::*;

  localparam int PROD_W = FREQ_W + SCALE_W + 1;
  localparam logic signed [PROD_W-1:0] STEP_CLIP = 81'sh8000_0000;
  localparam logic [SYNC_W-1:0] SYNC_TOP = 33'h1_0000_0000;
  localparam int QUARTER       = 16384;
  localparam int THREE_QUARTER = 49152;
  localparam int HALF_SPAN     = 32768;
  localparam int FULL_SPAN     = 65536;

  // predictor state
  logic [SCALE_W-1:0] scale_q;
  phase_t             osc_phase;
  phase_t             last_offset;
  wave_t              pending_waves[$];
  wave_t              want_wave;
  wave_t              new_wave;
  logic               end_checked;

  initial begin
    fail_count    = 0;
    waves_pending = 0;
    waves_checked = 0;
    sync_loads    = 0;
    clipped_steps = 0;
    end_checked   = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] wave mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // one audio sample: sync or offset delta, fold, then advance by the clipped step
  task automatic predict_wave(input logic signed [FREQ_W-1:0] freq, input phase_t offset,
                              input logic [SYNC_W-1:0] sync, output wave_t w);
    logic signed [PROD_W-1:0] f_ext;
    logic signed [PROD_W-1:0] s_ext;
    logic signed [PROD_W-1:0] raw_step;
    phase_t                   step;
    int                       p;
    int                       wv;
    f_ext    = freq;
    s_ext    = {33'd0, scale_q};
    raw_step = (f_ext * s_ext) >>> 32;
    if (raw_step > STEP_CLIP) begin
      raw_step = STEP_CLIP;
      clipped_steps++;
    end else if (raw_step < -STEP_CLIP) begin
      raw_step = -STEP_CLIP;
      clipped_steps++;
    end
    step = raw_step[PHASE_W-1:0];
    if (sync != '0 && sync <= SYNC_TOP) begin
      osc_phase = sync[PHASE_W-1:0];
      sync_loads++;
    end else begin
      osc_phase = osc_phase + (offset - last_offset);
    end
    p = int'(osc_phase[PHASE_W-1 -: WAVE_W]);
    if (p < QUARTER) begin
      wv = p;
    end else if (p < THREE_QUARTER) begin
      wv = HALF_SPAN - p;
    end else begin
      wv = p - FULL_SPAN;
    end
    w           = wave_t'(wv);
    osc_phase   = osc_phase + step;
    last_offset = offset;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_q     = STEP_SCALE_RST;
      osc_phase   = '0;
      last_offset = '0;
      pending_waves.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale_q = cfg_step_scale;
      end
      if (in_valid && !in_stall) begin
        predict_wave(in_frequency, in_offset, in_sync_phase, new_wave);
        pending_waves.push_back(new_wave);
      end
      if (out_valid && !out_stall) begin
        if (pending_waves.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, wave %0d", out_wave));
        end else begin
          want_wave = pending_waves.pop_front();
          if (out_wave !== want_wave) begin
            report_mismatch($sformatf("beat %0d: wave %0d, expected %0d",
                                      waves_checked, out_wave, want_wave));
          end
          waves_checked++;
        end
      end
      if (end_check && !end_checked) begin
        end_checked = 1'b1;
        foreach (pending_waves[i]) begin
          report_mismatch($sformatf("missing beat, expected wave %0d", pending_waves[i]));
        end
      end
    end
    waves_pending = pending_waves.size();
  end

endmodule
`default_nettype wire

/* dv/tb_triangle_oscillator_sync_pm.sv */
// Testbench top for the triangle oscillator: clock, reset, stimulus and verdict.
`default_nettype none
module tb_triangle_oscillator_sync_pm;

  timeunit 1ns;
  timeprecision 1ps;

  import tos_pkg::*;

  localparam int RUN_LIMIT    = 500_000;  // cycles
  localparam int TAIL_CYCLES  = 8;        // four-stage pipe plus margin
  localparam int PHASE_BEATS  = 130;      // random beats per step_scale setting
  localparam int RAND_PHASES  = 5;
  localparam logic [SYNC_W-1:0]  SYNC_WRAP  = 33'h1_0000_0000;  // reads as phase zero
  localparam logic [SCALE_W-1:0] SCALE_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_MIN  = 48'd1;
  localparam logic [SCALE_W-1:0] SCALE_44K1 = 48'd1633959048479;  // round(2^56 / 44100)
  localparam logic signed [FREQ_W-1:0] FREQ_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [FREQ_W-1:0] FREQ_MIN  = 32'sh8000_0000;
  localparam logic signed [FREQ_W-1:0] FREQ_A440 = 32'sd112640;   // 440 Hz in Q24.8
  localparam int AUDIO_MAX = 5_120_000;                            // 20 kHz in Q24.8

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [FREQ_W-1:0]    in_frequency;
  logic [PHASE_W-1:0]          in_offset;
  logic [SYNC_W-1:0]           in_sync_phase;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [WAVE_W-1:0]    out_wave;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [SCALE_W-1:0]          cfg_step_scale;
  logic                        end_check;

  int fail_count;
  int waves_pending;
  int waves_checked;
  int sync_loads;
  int clipped_steps;
  int cycle_count = 0;
  int scale_settings = 1;  // reset value counts as the first
  bit quiet;               // when set, neither side inserts gaps
  phase_t offset_sent;     // last phase offset driven, for small-delta modulation

  triangle_oscillator_sync_pm DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frequency   (in_frequency),
    .in_offset      (in_offset),
    .in_sync_phase  (in_sync_phase),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_wave       (out_wave),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_step_scale (cfg_step_scale)
  );

  tos_wave_checker wave_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frequency   (in_frequency),
    .in_offset      (in_offset),
    .in_sync_phase  (in_sync_phase),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_wave       (out_wave),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_step_scale (cfg_step_scale),
    .end_check      (end_check),
    .fail_count     (fail_count),
    .waves_pending  (waves_pending),
    .waves_checked  (waves_checked),
    .sync_loads     (sync_loads),
    .clipped_steps  (clipped_steps)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit. A hang anywhere (lost beat, stuck stall) ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("triangle_oscillator_sync_pm regression: fail");
      $finish;
    end
  end

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(3, 1);
    end else if (r < 97) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Result side back-pressure: runs of ready cycles broken by stalls of
  // random length, so stalls land on every pipeline stage.
  initial begin
    int run_len;
    int hold_len;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      out_stall <= 1'b0;
      run_len = $urandom_range(12, 1);
      repeat (run_len) @(negedge clk);
      hold_len = pick_gap();
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
      end
    end
  end

  // One input beat. Called and returns at a falling edge. With no gap, valid
  // stays high and only the payload moves on, so it is never dropped and
  // raised in the same step.
  task automatic send_beat(input logic signed [FREQ_W-1:0] freq, input phase_t offset,
                           input logic [SYNC_W-1:0] sync);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_frequency    <= freq;
    in_offset       <= offset;
    in_sync_phase   <= sync;
    offset_sent      = offset;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off until every expected sample is back, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (waves_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // step_scale write; only called with the pipe empty.
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_step_scale <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    scale_settings++;
  endtask

  // Random sample mixing audio-rate and LFO frequencies, range extremes,
  // phase modulation by held / small / wild offsets, and occasional sync
  // words, including 2^32 and values above the sync range.
  task automatic send_random_beat();
    logic signed [FREQ_W-1:0] freq;
    phase_t                   offset;
    logic [SYNC_W-1:0]        sync;
    logic [PHASE_W-1:0]       word;
    int                       r;
    r = $urandom_range(99);
    if (r < 45) begin
      freq = $urandom_range(AUDIO_MAX, 0);
    end else if (r < 60) begin
      freq = $urandom_range(2560, 0);  // up to 10 Hz
    end else if (r < 75) begin
      case ($urandom_range(4))
        0: freq = '0;
        1: freq = 32'sd1;
        2: freq = -32'sd1;
        3: freq = FREQ_MAX;
        default: freq = FREQ_MIN;
      endcase
    end else begin
      freq = $urandom;
    end
    if (r < 60 && $urandom_range(1) == 1) begin
      freq = -freq;
    end

    r = $urandom_range(99);
    if (r < 50) begin
      offset = offset_sent;  // no modulation this sample
    end else if (r < 75) begin
      offset = offset_sent + {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
    end else if (r < 90) begin
      offset = $urandom;
    end else begin
      case ($urandom_range(2))
        0: offset = '0;
        1: offset = '1;
        default: offset = HALF_CYCLE;
      endcase
    end

    r = $urandom_range(99);
    if (r < 75) begin
      sync = '0;
    end else if (r < 88) begin
      sync = {1'b0, 32'($urandom)};
    end else if (r < 92) begin
      sync = SYNC_WRAP;
    end else if (r < 95) begin
      sync = 33'd1;
    end else begin
      word = $urandom;
      if (word == '0) begin
        word = 32'd1;
      end
      sync = {1'b1, word};  // above range: no sync
    end
    send_beat(freq, offset, sync);
  endtask

  initial begin
    logic [SCALE_W-1:0] scale_pick;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_frequency    = '0;
    in_offset       = '0;
    in_sync_phase   = '0;
    cfg_valid       = 1'b0;
    cfg_step_scale  = '0;
    end_check       = 1'b0;
    quiet           = 1'b0;
    offset_sent     = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, step_scale at its reset value (48 kHz).
    send_beat('0, '0, '0);                          // all zero
    send_beat(FREQ_MAX, '0, '0);                    // step clips to +half cycle
    send_beat(FREQ_MIN, '0, '0);                    // step clips to -half cycle
    send_beat(-32'sd1, '0, '0);                     // tiny negative step, floor
    send_beat(FREQ_A440, '0, SYNC_WRAP);            // sync of 2^32 loads zero
    send_beat('0, '0, 33'd1);                       // smallest sync
    send_beat('0, '0, 33'h0_FFFF_FFFF);             // largest sync below wrap
    send_beat('0, '0, 33'h0_3FFF_FFFF);             // just under the positive peak
    send_beat('0, '0, 33'h0_4000_0000);             // positive peak
    send_beat('0, '0, 33'h0_BFFF_FFFF);             // just under the negative peak
    send_beat('0, '0, 33'h0_C000_0000);             // negative peak
    send_beat('0, '0, 33'h0_8000_0000);             // mid falling edge, zero
    send_beat('0, '0, 33'h1_0000_0001);             // above range, no sync
    send_beat('0, '1, 33'h1_FFFF_FFFF);             // offset jump of almost a cycle
    send_beat('0, '0, '0);                          // offset jump back across the wrap
    send_beat('0, HALF_CYCLE, '0);                  // half-cycle offset jump
    drain_results();

    // Largest scale: unit frequencies give steps of 65535 and -65536; the extremes clip.
    write_scale(SCALE_MAX);
    send_beat(32'sd1, '0, '0);
    send_beat(-32'sd1, '0, '0);
    send_beat(FREQ_MAX, '0, '0);
    send_beat(FREQ_MIN, '0, '0);
    drain_results();

    // Smallest scale: steps collapse to 0 or -1.
    write_scale(SCALE_MIN);
    send_beat(FREQ_MAX, '0, '0);
    send_beat(-32'sd1, '0, '0);
    send_beat(FREQ_MIN, '0, '0);
    drain_results();

    // Random phases, one step_scale setting each. The second phase runs
    // with no idling on either side; the third pauses halfway until every
    // sample is back.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: scale_pick = STEP_SCALE_RST;
        1: scale_pick = SCALE_44K1;
        2: scale_pick = {16'($urandom), 32'($urandom)};
        3: scale_pick = 48'($urandom_range(65535, 1));
        default: scale_pick = SCALE_MAX;
      endcase
      if (scale_pick == '0) begin
        scale_pick = SCALE_MIN;
      end
      write_scale(scale_pick);
      quiet = (ph == 1);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_random_beat();
        if (ph == 2 && n == PHASE_BEATS / 2) begin
          drain_results();
        end
      end
      drain_results();
      quiet = 1'b0;
    end

    // Anything still owed is reported by the checker.
    end_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("covered %0d samples over %0d step_scale settings,", waves_checked,
             scale_settings);
    $display("with %0d sync loads and %0d clipped steps", sync_loads, clipped_steps);
    if (fail_count == 0) begin
      $display("triangle_oscillator_sync_pm regression: pass");
    end else begin
      $display("triangle_oscillator_sync_pm regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* triangle_oscillator_sync_pm.f */
hdl/tos_pkg.sv
hdl/tos_step.sv
hdl/tos_phase.sv
hdl/triangle_oscillator_sync_pm.sv
dv/tos_wave_checker.sv
dv/tb_triangle_oscillator_sync_pm.sv
